// ----- sv/sha256d_nonce_search_top_macros.svh -----
// Assertion macros for the nonce search checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef SHA256D_NONCE_SEARCH_TOP_MACROS_SVH
`define SHA256D_NONCE_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define SHAD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shad check failed");

// Next-cycle implication, disabled in reset
`define SHAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shad check failed");

`endif

// ----- sv/shad_pkg.sv -----
// Shared types, constants and SHA-256 helper functions for the nonce search.
// No dependencies.
package shad_pkg;

  typedef enum logic [3:0] {
    CFG_MID_AB   = 4'd0,
    CFG_MID_CD   = 4'd1,
    CFG_MID_EF   = 4'd2,
    CFG_MID_GH   = 4'd3,
    CFG_TAIL_01  = 4'd4,
    CFG_TAIL_2   = 4'd5,
    CFG_TARGET   = 4'd6,
    CFG_LIMIT    = 4'd7
  } cfg_index_t;

  // word 0 is a, word 7 is h
  typedef logic [7:0][31:0]  state_t;
  typedef logic [15:0][31:0] window_t;

  typedef struct packed {
    state_t     h;
    window_t    w;
    logic [31:0] tag;
  } stage_t;

  localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
  localparam logic [31:0] LEN_FIRST = 32'h0000_0280;
  localparam logic [31:0] LEN_SECOND = 32'h0000_0100;
  localparam int unsigned ROUNDS = 64;

  localparam logic [31:0] INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] v);
    bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ----- sv/shad_round_cell.sv -----
// One SHA-256 round plus one message schedule step, registered.
// Depends on shad_pkg.
module shad_round_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  shad_pkg::stage_t in_stage,
  output logic            out_valid,
  output shad_pkg::stage_t out_stage
);

  localparam logic [31:0] K = shad_pkg::ROUND_K[6'(IDX)];

  shad_pkg::stage_t stage_next;
  logic [31:0] t1, t2, ch, mj;

  always_comb begin
    ch = (in_stage.h[4] & in_stage.h[5]) ^ (~in_stage.h[4] & in_stage.h[6]);
    mj = (in_stage.h[0] & in_stage.h[1]) ^ (in_stage.h[0] & in_stage.h[2]) ^
         (in_stage.h[1] & in_stage.h[2]);
    t1 = in_stage.h[7] + shad_pkg::bsig1(in_stage.h[4]) + ch + K + in_stage.w[0];
    t2 = shad_pkg::bsig0(in_stage.h[0]) + mj;
    stage_next.h[0] = t1 + t2;
    stage_next.h[1] = in_stage.h[0];
    stage_next.h[2] = in_stage.h[1];
    stage_next.h[3] = in_stage.h[2];
    stage_next.h[4] = in_stage.h[3] + t1;
    stage_next.h[5] = in_stage.h[4];
    stage_next.h[6] = in_stage.h[5];
    stage_next.h[7] = in_stage.h[6];
    for (int j = 0; j < 15; j++) begin
      stage_next.w[j] = in_stage.w[j+1];
    end
    // schedule window slides by one word per round
    stage_next.w[15] = in_stage.w[0] + shad_pkg::ssig0(in_stage.w[1]) + in_stage.w[9] +
                       shad_pkg::ssig1(in_stage.w[14]);
    stage_next.tag = in_stage.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ----- sv/shad_compress.sv -----
// Full SHA-256 compression as a row of 64 round cells and a feed-forward stage.
// Depends on shad_pkg and shad_round_cell. Chain must hold steady while items are in flight.
module shad_compress (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  shad_pkg::state_t  chain,
  input  shad_pkg::window_t blk,
  input  logic [31:0]      tag_in,
  output logic             out_valid,
  output shad_pkg::state_t  digest,
  output logic [31:0]      tag_out
);

  shad_pkg::stage_t stg [0:shad_pkg::ROUNDS];
  logic             vld [0:shad_pkg::ROUNDS];

  assign vld[0]     = in_valid;
  assign stg[0].h   = chain;
  assign stg[0].w   = blk;
  assign stg[0].tag = tag_in;

  for (genvar i = 0; i < shad_pkg::ROUNDS; i++) begin : g_cell
    shad_round_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .in_stage  (stg[i]),
      .out_valid (vld[i+1]),
      .out_stage (stg[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[shad_pkg::ROUNDS];
    end
    if (en) begin
      for (int j = 0; j < 8; j++) begin
        digest[j] <= chain[j] + stg[shad_pkg::ROUNDS].h[j];
      end
      tag_out <= stg[shad_pkg::ROUNDS].tag;
    end
  end

endmodule

// ----- sv/sha256d_nonce_search_top.sv -----
// Double SHA-256 nonce search: config registers, two compression rows, hit counter.
// Depends on shad_pkg and shad_compress.
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | nonce
//  out     | out_valid / out_ready | hit, stored, slot, nonce_out
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One nonce per cycle while the result is not stalled; two 64-cell rows, each with a
// feed-forward stage, then the result register.
// The whole pipeline advances together; a stalled result stops it and drops in_ready.
// Synchronous reset clears valid bits, config registers and the hit counter.
// cfg_ready is always high.
module sha256d_nonce_search_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] nonce,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic        stored,
  output logic [31:0] slot,
  output logic [31:0] nonce_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] mid_ab, mid_cd, mid_ef, mid_gh, tail_01, target_pair;
  logic [31:0] tail_2;
  logic [15:0] result_limit;
  logic [31:0] hit_count;

  logic en;
  shad_pkg::state_t  chain1, chain2, dig1, dig2;
  shad_pkg::window_t blk1, blk2;
  logic v1, v2;
  logic [31:0] tag1, tag2;
  logic hit_next;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_ab <= '0; mid_cd <= '0; mid_ef <= '0; mid_gh <= '0;
      tail_01 <= '0; tail_2 <= '0; target_pair <= '0; result_limit <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        shad_pkg::CFG_MID_AB:  mid_ab       <= cfg_data;
        shad_pkg::CFG_MID_CD:  mid_cd       <= cfg_data;
        shad_pkg::CFG_MID_EF:  mid_ef       <= cfg_data;
        shad_pkg::CFG_MID_GH:  mid_gh       <= cfg_data;
        shad_pkg::CFG_TAIL_01: tail_01      <= cfg_data;
        shad_pkg::CFG_TAIL_2:  tail_2       <= cfg_data[31:0];
        shad_pkg::CFG_TARGET:  target_pair  <= cfg_data;
        shad_pkg::CFG_LIMIT:   result_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    chain1[0] = mid_ab[63:32]; chain1[1] = mid_ab[31:0];
    chain1[2] = mid_cd[63:32]; chain1[3] = mid_cd[31:0];
    chain1[4] = mid_ef[63:32]; chain1[5] = mid_ef[31:0];
    chain1[6] = mid_gh[63:32]; chain1[7] = mid_gh[31:0];
    blk1     = '0;
    blk1[0]  = tail_01[63:32];
    blk1[1]  = tail_01[31:0];
    blk1[2]  = tail_2;
    blk1[3]  = nonce;
    blk1[4]  = shad_pkg::PAD_WORD;
    blk1[15] = shad_pkg::LEN_FIRST;
    blk2     = '0;
    for (int j = 0; j < 8; j++) begin
      chain2[j] = shad_pkg::INIT_H[j];
      blk2[j]   = dig1[j];
    end
    blk2[8]  = shad_pkg::PAD_WORD;
    blk2[15] = shad_pkg::LEN_SECOND;
  end

  shad_compress u_first (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .chain(chain1), .blk(blk1), .tag_in(nonce),
    .out_valid(v1), .digest(dig1), .tag_out(tag1)
  );

  shad_compress u_second (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .chain(chain2), .blk(blk2), .tag_in(tag1),
    .out_valid(v2), .digest(dig2), .tag_out(tag2)
  );

  assign hit_next = (dig2[7] == 32'd0) &&
                    (shad_pkg::bswap(dig2[6]) <= target_pair[63:32]) &&
                    (shad_pkg::bswap(dig2[5]) <= target_pair[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hit_count <= '0;
    end else if (en) begin
      out_valid <= v2;
      // counter saturates at all ones
      if (v2 && hit_next && hit_count != '1) begin
        hit_count <= hit_count + 32'd1;
      end
    end
    if (en) begin
      hit       <= hit_next;
      stored    <= hit_next && (hit_count < {16'd0, result_limit});
      slot      <= hit_next ? hit_count : 32'd0;
      nonce_out <= tag2;
    end
  end

endmodule

// ----- sv/shad_checker.sv -----
// Port-level assertions for the nonce search top, bound to it below.
// Depends on sha256d_nonce_search_top_macros.svh.
`include "sha256d_nonce_search_top_macros.svh"

module shad_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic        stored,
  input logic [31:0] slot,
  input logic [31:0] nonce_out
);

  `SHAD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(nonce_out))
  `SHAD_ASSERT_IMP(a_stored_hit, out_valid && stored, hit)
  `SHAD_ASSERT_IMP(a_nohit_slot, out_valid && !hit, slot == 32'd0 && !stored)
  `SHAD_ASSERT_IMP(a_ready_flow, 1'b1, in_ready == (!out_valid || out_ready))

endmodule

bind sha256d_nonce_search_top shad_checker u_shad_checker (.*);
